>>> src/rdp_pkg.sv
// Shared types, constants and helper functions for the register dump parser.
`default_nettype none

package rdp_pkg;

	localparam int REG_LIMIT_DEF = 32;
	localparam int BUF_POS_DEF   = 4096;

	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W       = 2;
	localparam int LVL_W       = 3;

	localparam int INDEX_W  = 5;
	localparam int START_W  = 12;
	localparam int LENGTH_W = 12;
	localparam int VALUE_W  = 64;
	localparam int TOTAL_W  = 6;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_TICK  = 8'h60;
	localparam logic [7:0] CH_DIG0  = 8'h30;
	localparam logic [7:0] CH_DIG9  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_F = 8'h66;
	localparam logic [7:0] HEX_TEN  = 8'd10;

	typedef enum logic [2:0] {
		MODE_SKIP_WS,
		MODE_NAME,
		MODE_VALUE,
		MODE_SKIP_TOKEN,
		MODE_DONE
	} mode_t;

	typedef enum logic {
		KIND_REGISTER = 1'b0,
		KIND_SUMMARY  = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t                kind;
		logic [INDEX_W-1:0]   index;
		logic [START_W-1:0]   start;
		logic [LENGTH_W-1:0]  length;
		logic [VALUE_W-1:0]   value;
		logic [TOTAL_W-1:0]   total;
		logic                 last;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} result_pair_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] digit;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h = '0;
		if (c >= CH_DIG0 && c <= CH_DIG9) begin
			h.valid = 1'b1;
			h.digit = 4'(c - CH_DIG0);
		end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
			h.valid = 1'b1;
			h.digit = 4'(c - CH_LOW_A + HEX_TEN);
		end else if (c >= CH_UP_A && c <= CH_UP_F) begin
			h.valid = 1'b1;
			h.digit = 4'(c - CH_UP_A + HEX_TEN);
		end
		return h;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
	endfunction

endpackage

`default_nettype wire

>>> src/rdp_parse_core.sv
// Parser state and the per-byte update that yields up to two result records.
`default_nettype none

module rdp_parse_core #(
	parameter int REGISTER_LIMIT   = rdp_pkg::REG_LIMIT_DEF,
	parameter int BUFFER_POSITIONS = rdp_pkg::BUF_POS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire logic [7:0]           char_code,
	output rdp_pkg::result_pair_t     results
);
	import rdp_pkg::*;

	localparam int POS_W = $clog2(BUFFER_POSITIONS);
	localparam int CNT_W = $clog2(REGISTER_LIMIT + 1);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(BUFFER_POSITIONS - 1);
	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(REGISTER_LIMIT);

	mode_t              mode_q, mode_d;
	logic [CNT_W-1:0]   found_q, found_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [POS_W-1:0]   start_q, start_d;
	logic [POS_W-1:0]   len_q, len_d;
	logic [VALUE_W-1:0] acc_q, acc_d;

	hex_t             hx;
	logic [CNT_W-1:0] found_inc;
	logic             value_end;
	result_t          reg_rec;

	assign hx        = hex_decode(char_code);
	assign found_inc = found_q + 1'b1;
	assign value_end = (mode_q == MODE_VALUE) && (char_code != CH_NUL) && !hx.valid
		&& (char_code != CH_TICK);

	always_comb begin
		mode_d  = mode_q;
		found_d = found_q;
		pos_d   = pos_q;
		start_d = start_q;
		len_d   = len_q;
		acc_d   = acc_q;
		if (char_code == CH_NUL) begin
			mode_d  = MODE_SKIP_WS;
			found_d = '0;
			pos_d   = '0;
			start_d = '0;
			len_d   = '0;
			acc_d   = '0;
		end else begin
			if (mode_q == MODE_VALUE && hx.valid) begin
				acc_d = {acc_q[VALUE_W-5:0], hx.digit};
			end else if (value_end) begin
				found_d = found_inc;
				mode_d  = (found_inc >= CNT_LIMIT) ? MODE_DONE : MODE_SKIP_WS;
			end
			if (mode_d == MODE_SKIP_TOKEN && char_code == CH_SPACE) begin
				mode_d = MODE_SKIP_WS;
			end
			if (mode_d == MODE_SKIP_WS && !is_space(char_code)) begin
				start_d = pos_q;
				len_d   = '0;
				mode_d  = MODE_NAME;
			end
			if (mode_d == MODE_NAME) begin
				priority if (char_code == CH_EQ) begin
					acc_d  = '0;
					mode_d = MODE_VALUE;
				end else if (char_code == CH_SPACE) begin
					mode_d = MODE_SKIP_WS;
				end else if (char_code == CH_TAB) begin
					mode_d = MODE_SKIP_TOKEN;
				end else begin
					if (len_d < POS_LAST) begin
						len_d = len_d + 1'b1;
					end
				end
			end
			pos_d = (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
		end
	end

	always_comb begin
		reg_rec        = '0;
		reg_rec.kind   = KIND_REGISTER;
		reg_rec.index  = INDEX_W'(found_q);
		reg_rec.start  = START_W'(start_q);
		reg_rec.length = LENGTH_W'(len_q);
		reg_rec.value  = acc_q;

		results = '0;
		if (char_code == CH_NUL) begin
			if (mode_q == MODE_VALUE) begin
				results.count        = 2'd2;
				results.first        = reg_rec;
				results.second.kind  = KIND_SUMMARY;
				results.second.total = TOTAL_W'(found_inc);
				results.second.last  = 1'b1;
			end else begin
				results.count       = 2'd1;
				results.first.kind  = KIND_SUMMARY;
				results.first.total = TOTAL_W'(found_q);
				results.first.last  = 1'b1;
			end
		end else if (value_end) begin
			results.count      = 2'd1;
			results.first      = reg_rec;
			results.first.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_SKIP_WS;
			found_q <= '0;
			pos_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
			acc_q   <= '0;
		end else if (step) begin
			mode_q  <= mode_d;
			found_q <= found_d;
			pos_q   <= pos_d;
			start_q <= start_d;
			len_q   <= len_d;
			acc_q   <= acc_d;
		end
	end

endmodule

`default_nettype wire

>>> src/rdp_out_queue.sv
// Small result queue: takes up to two records per cycle, hands out one.
`default_nettype none

module rdp_out_queue (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire rdp_pkg::result_pair_t      push,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output rdp_pkg::result_t                head,
	output logic [rdp_pkg::LVL_W-1:0]       level
);
	import rdp_pkg::*;

	result_t          ent_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	logic             pop;

	assign out_valid = (level_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = ent_q[rd_ptr_q];
	assign level     = level_q;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			ent_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			ent_q[PTR_W'(wr_ptr_q + 1'b1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= PTR_W'(wr_ptr_q + PTR_W'(push.count));
			rd_ptr_q <= PTR_W'(rd_ptr_q + PTR_W'(pop));
			level_q  <= LVL_W'(level_q + LVL_W'(push.count) - LVL_W'(pop));
		end
	end

endmodule

`default_nettype wire

>>> src/register_dump_parser.sv
// Register dump parser: one text byte per item in, register and summary records out.
// One byte is taken every cycle while the result queue has room. A byte is held in the
// input register while the parser updates its state, and its records are written into a
// four-entry result queue that drives the output. Most bytes give no record; a byte that
// closes a value gives one; the zero byte gives the summary, preceded by the last register
// record when the buffer ends inside a value, and those two records are handed out one at a
// time. Input is held off only while the queue has fewer than two free entries.
`default_nettype none

module register_dump_parser #(
	parameter int REGISTER_LIMIT   = rdp_pkg::REG_LIMIT_DEF,
	parameter int BUFFER_POSITIONS = rdp_pkg::BUF_POS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [7:0]                     char_code,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                record_kind,
	output logic [rdp_pkg::INDEX_W-1:0]         reg_index,
	output logic [rdp_pkg::START_W-1:0]         name_start,
	output logic [rdp_pkg::LENGTH_W-1:0]        name_length,
	output logic [rdp_pkg::VALUE_W-1:0]         reg_value,
	output logic [rdp_pkg::TOTAL_W-1:0]         total_registers,
	output logic                                last_of_run
);
	import rdp_pkg::*;

	logic         valid_s1;
	logic [7:0]   char_s1;
	logic         room;
	logic         advance;
	result_pair_t results;
	result_pair_t push;
	result_t      head;
	logic [LVL_W-1:0] level;

	assign room     = (level <= LVL_W'(QUEUE_DEPTH - 2));
	assign advance  = valid_s1 && room;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_code;
		end
	end

	rdp_parse_core #(
		.REGISTER_LIMIT   (REGISTER_LIMIT),
		.BUFFER_POSITIONS (BUFFER_POSITIONS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.char_code (char_s1),
		.results   (results)
	);

	always_comb begin
		push = results;
		if (!advance) begin
			push.count = 2'd0;
		end
	end

	rdp_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head),
		.level     (level)
	);

	assign record_kind     = head.kind;
	assign reg_index       = head.index;
	assign name_start      = head.start;
	assign name_length     = head.length;
	assign reg_value       = head.value;
	assign total_registers = head.total;
	assign last_of_run     = head.last;

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= LVL_W'(QUEUE_DEPTH))
		else $error("result queue overfilled");

	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind == KIND_SUMMARY |-> last_of_run)
		else $error("summary record not marked last");

	a_pair_queued: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> level >= LVL_W'(2))
		else $error("record pair split in queue");

	a_pair_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> record_kind == KIND_REGISTER)
		else $error("non-last record is not a register record");

endmodule

`default_nettype wire

>>> tb/register_dump_parser_test.sv
// Self-checking testbench for the register dump parser: directed table, then random dumps.
module register_dump_parser_test;
	import rdp_pkg::*;

	localparam int WATCHDOG_CYCLES = 2000;
	localparam int RANDOM_ITEMS    = 1300;
	localparam int MAX_SHOWN       = 40;
	localparam int NAME_MAX        = BUF_POS_DEF - 1;
	localparam int DIRECTED_ROWS   = 23;

	typedef struct {
		logic [7:0] ch;
		bit         typed;
		result_t    rec;
	} stim_row_t;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	logic [7:0]          char_code = CH_NUL;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                record_kind;
	logic [INDEX_W-1:0]  reg_index;
	logic [START_W-1:0]  name_start;
	logic [LENGTH_W-1:0] name_length;
	logic [VALUE_W-1:0]  reg_value;
	logic [TOTAL_W-1:0]  total_registers;
	logic                last_of_run;

	// shadow parser state
	mode_t               dump_mode;
	int unsigned         regs_found;
	logic [START_W-1:0]  byte_pos;
	logic [START_W-1:0]  name_pos;
	logic [LENGTH_W-1:0] name_len;
	logic [VALUE_W-1:0]  value_acc;

	result_t step_records[$];
	result_t expected_records[$];

	int mismatch_count = 0;
	int records_seen   = 0;
	int live_items     = 0;
	int quiet_cycles   = 0;
	int last_gap       = 0;
	bit sender_steady  = 1'b0;
	bit sink_steady    = 1'b0;

	string blank_chars = " \t\r\n";
	string hex_chars   = "0123456789abcdefABCDEF";
	string closer_chars = "\t\r\n ,;:xyz";

	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{CH_NUL, 1'b1, '{KIND_SUMMARY, 5'd0, 12'd0, 12'd0, 64'd0, 6'd0, 1'b1}},
		'{8'h41, 1'b0, '0},
		'{CH_EQ, 1'b0, '0},
		'{8'h66, 1'b0, '0},
		'{8'h66, 1'b0, '0},
		'{CH_SPACE, 1'b1, '{KIND_REGISTER, 5'd0, 12'd0, 12'd1, 64'hff, 6'd0, 1'b1}},
		'{CH_EQ, 1'b0, '0},
		'{CH_TICK, 1'b0, '0},
		'{8'h31, 1'b0, '0},
		'{CH_TAB, 1'b1, '{KIND_REGISTER, 5'd1, 12'd5, 12'd0, 64'h1, 6'd0, 1'b1}},
		'{8'h78, 1'b0, '0},
		'{CH_TAB, 1'b0, '0},
		'{8'h79, 1'b0, '0},
		'{CH_SPACE, 1'b0, '0},
		'{CH_CR, 1'b0, '0},
		'{CH_LF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'h42, 1'b0, '0},
		'{CH_EQ, 1'b0, '0},
		'{8'h46, 1'b0, '0},
		'{CH_NUL, 1'b0, '0},
		'{8'h71, 1'b0, '0},
		'{CH_NUL, 1'b1, '{KIND_SUMMARY, 5'd0, 12'd0, 12'd0, 64'd0, 6'd0, 1'b1}}
	};

	register_dump_parser DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.char_code       (char_code),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.record_kind     (record_kind),
		.reg_index       (reg_index),
		.name_start      (name_start),
		.name_length     (name_length),
		.reg_value       (reg_value),
		.total_registers (total_registers),
		.last_of_run     (last_of_run)
	);

	function automatic void clear_dump();
		dump_mode  = MODE_SKIP_WS;
		regs_found = 0;
		byte_pos   = '0;
		name_pos   = '0;
		name_len   = '0;
		value_acc  = '0;
	endfunction

	function automatic void emit_register(input logic is_last);
		result_t r;
		r        = '0;
		r.kind   = KIND_REGISTER;
		r.index  = INDEX_W'(regs_found);
		r.start  = name_pos;
		r.length = name_len;
		r.value  = value_acc;
		r.last   = is_last;
		step_records.push_back(r);
		regs_found++;
	endfunction

	function automatic void parse_char(input logic [7:0] ch);
		result_t    r;
		logic       is_hex;
		logic       blank;
		logic [3:0] nibble;
		step_records.delete();
		is_hex = (ch >= CH_DIG0 && ch <= CH_DIG9) || (ch >= CH_LOW_A && ch <= CH_LOW_F) ||
			(ch >= CH_UP_A && ch <= CH_UP_F);
		// letters sit at xx1 in both cases, so low nibble + 9 gives 10..15
		nibble = ch[3:0] + (ch[6] ? 4'd9 : 4'd0);
		blank = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) || (ch == CH_CR);

		if (ch == CH_NUL) begin
			if (dump_mode == MODE_VALUE)
				emit_register(1'b0);
			r       = '0;
			r.kind  = KIND_SUMMARY;
			r.total = TOTAL_W'(regs_found);
			r.last  = 1'b1;
			step_records.push_back(r);
			clear_dump();
			return;
		end

		if (dump_mode == MODE_VALUE) begin
			if (is_hex) begin
				value_acc = {value_acc[VALUE_W-5:0], nibble};
			end else if (ch != CH_TICK) begin
				emit_register(1'b1);
				dump_mode = (regs_found >= REG_LIMIT_DEF) ? MODE_DONE : MODE_SKIP_WS;
			end
		end

		if (dump_mode == MODE_SKIP_TOKEN && ch == CH_SPACE)
			dump_mode = MODE_SKIP_WS;

		if (dump_mode == MODE_SKIP_WS && !blank) begin
			name_pos  = byte_pos;
			name_len  = '0;
			dump_mode = MODE_NAME;
		end

		if (dump_mode == MODE_NAME) begin
			if (ch == CH_EQ) begin
				value_acc = '0;
				dump_mode = MODE_VALUE;
			end else if (ch == CH_SPACE) begin
				dump_mode = MODE_SKIP_WS;
			end else if (ch == CH_TAB) begin
				dump_mode = MODE_SKIP_TOKEN;
			end else if (name_len < NAME_MAX) begin
				name_len++;
			end
		end

		byte_pos++;
	endfunction

	function automatic logic [7:0] name_char();
		logic [7:0] ch;
		ch = 8'($urandom_range(8'h21, 8'h7E));
		if (ch == CH_EQ)
			ch = CH_UP_A;
		return ch;
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
		input logic [63:0] want);
		if (mismatch_count < MAX_SHOWN)
			$display("mismatch in record %0d, %s: got %h, expected %h",
				records_seen, field, got, want);
		mismatch_count++;
	endtask

	task automatic check_record();
		result_t want;
		records_seen++;
		if (expected_records.size() == 0) begin
			report_mismatch("unexpected record", {63'd0, record_kind}, '0);
			return;
		end
		want = expected_records.pop_front();
		if (record_kind !== want.kind)
			report_mismatch("record_kind", record_kind, want.kind);
		if (reg_index !== want.index)
			report_mismatch("reg_index", reg_index, want.index);
		if (name_start !== want.start)
			report_mismatch("name_start", name_start, want.start);
		if (name_length !== want.length)
			report_mismatch("name_length", name_length, want.length);
		if (reg_value !== want.value)
			report_mismatch("reg_value", reg_value, want.value);
		if (total_registers !== want.total)
			report_mismatch("total_registers", total_registers, want.total);
		if (last_of_run !== want.last)
			report_mismatch("last_of_run", last_of_run, want.last);
	endtask

	task automatic send_char(input logic [7:0] ch, input bit typed = 1'b0,
		input result_t typed_rec = '0);
		in_valid  <= 1'b1;
		char_code <= ch;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (dump_mode != MODE_DONE)
			live_items++;
		parse_char(ch);
		if (typed)
			expected_records.push_back(typed_rec);
		else
			foreach (step_records[i])
				expected_records.push_back(step_records[i]);
		last_gap = sender_steady ? 0 : $urandom_range(0, 8);
		if (last_gap != 0) begin
			in_valid <= 1'b0;
			repeat (last_gap) @(posedge clk);
		end
	endtask

	task automatic send_dump(input int regs);
		int         k;
		int         n;
		int         shape;
		logic [7:0] sep;
		sender_steady = ($urandom_range(0, 3) == 0);
		for (k = 0; k < regs; k++) begin
			repeat ($urandom_range(0, 2)) send_char(blank_chars[$urandom_range(0, 3)]);
			shape = $urandom_range(0, 15);
			if (shape == 0) begin
				repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(1, 255)));
			end else if (shape == 1) begin
				// token with no '=': a tab skips the rest of it up to a space
				repeat ($urandom_range(1, 5)) send_char(name_char());
				sep = ($urandom_range(0, 1) != 0) ? CH_TAB : CH_SPACE;
				send_char(sep);
				if (sep == CH_TAB) begin
					repeat ($urandom_range(0, 3)) send_char(name_char());
					send_char(CH_SPACE);
				end
			end else begin
				repeat ((shape == 2) ? 0 : $urandom_range(1, 6)) send_char(name_char());
				send_char(CH_EQ);
				n = (shape == 3) ? $urandom_range(17, 24) : $urandom_range(0, 16);
				repeat (n) begin
					if ($urandom_range(0, 7) == 0)
						send_char(CH_TICK);
					send_char(hex_chars[$urandom_range(0, 21)]);
				end
				// shape 4 leaves the value open for whatever follows
				if (shape != 4)
					send_char(closer_chars[$urandom_range(0, closer_chars.len() - 1)]);
			end
		end
		send_char(CH_NUL);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		clear_dump();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == WATCHDOG_CYCLES) begin
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 31) == 0)
				sink_steady = !sink_steady;
			stall = sink_steady ? 0 : $urandom_range(0, 8);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			check_record();
		end
	end

	initial begin
		int regs;
		wait (arst_n === 1'b1);
		foreach (directed_rows[i])
			send_char(directed_rows[i].ch, directed_rows[i].typed, directed_rows[i].rec);

		// drain fully before the random dumps
		if (last_gap == 0)
			in_valid <= 1'b0;
		do @(posedge clk); while (expected_records.size() != 0);

		live_items = 0;
		while (live_items < RANDOM_ITEMS) begin
			regs = ($urandom_range(0, 9) == 0) ? $urandom_range(34, 44) : $urandom_range(0, 6);
			send_dump(regs);
		end

		if (last_gap == 0)
			in_valid <= 1'b0;
		do @(posedge clk); while (expected_records.size() != 0);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> files.f
src/rdp_pkg.sv
src/rdp_parse_core.sv
src/rdp_out_queue.sv
src/register_dump_parser.sv
tb/register_dump_parser_test.sv
